// ----- hw/rtl/gtl_pkg.sv -----
// Shared types, constants and arithmetic helpers for the geodetic to local NEU converter.
package gtl_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 35;

  localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_LAT    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_LON    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_ECEF_X = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_ECEF_Y = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_ECEF_Z = 3'd4;

  localparam int unsigned LANES    = 4;
  localparam int unsigned LANE_LAT  = 0;
  localparam int unsigned LANE_LON  = 1;
  localparam int unsigned LANE_OLAT = 2;
  localparam int unsigned LANE_OLON = 3;

  localparam int unsigned SQ_STEPS = 32;
  localparam int unsigned DV_STEPS = 33;

  localparam logic signed [32:0] ANG_TO_Q61     = 33'sd4024455255;
  localparam logic signed [63:0] PI_Q61         = 64'sd7244019458116584570;
  localparam logic signed [63:0] HALF_PI_Q61    = 64'sd3622009729058292285;
  localparam logic signed [63:0] QUARTER_PI_Q61 = 64'sd1811004864529146143;
  localparam logic signed [63:0] INV_GAIN_Q61   = 64'sd1400229935014726478;
  localparam logic [24:0]        E2_Q32         = 25'd28752143;
  localparam logic [32:0]        SEMI_MAJOR_MM  = 33'd6378137000;
  localparam logic signed [34:0] ORIGIN_X_RESET = 35'sd6378137000;
  localparam logic signed [36:0] ECEF_LIMIT     = 37'sd9000000000;
  localparam logic signed [38:0] NEU_LIMIT      = 39'sd18000000000;

  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
    logic               flip;
  } cordic_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] res;
  } sqrt_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [32:0] num;
    logic [31:0] divisor;
  } div_t;

  // Restoring long division, used only on constants at elaboration.
  function automatic logic [63:0] udiv_c(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem  = rem - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Arctangent of 2^-i in Q61 from the truncated power series.
  function automatic logic signed [63:0] atan_q61(input int unsigned i);
    logic signed [63:0] sum;
    logic [63:0]        term;
    int unsigned        s;
    sum = '0;
    if (i == 0) begin
      return QUARTER_PI_Q61;
    end
    for (int unsigned k = 0; k < 32; k++) begin
      s = i * (2 * k + 1);
      if (s <= 61) begin
        term = udiv_c(64'd1 << (61 - s), 64'(2 * k + 1));
        sum  = k[0] ? sum - $signed(term) : sum + $signed(term);
      end
    end
    return sum;
  endfunction

  // Round a Q61 value to Q1.30 and clamp to plus or minus one.
  function automatic logic signed [31:0] to_q30(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = (v + 64'sd1073741824) >>> 31;
    if (t > 64'sd1073741824) begin
      t = 64'sd1073741824;
    end
    if (t < -64'sd1073741824) begin
      t = -64'sd1073741824;
    end
    return 32'(t);
  endfunction

  // d * c / 2^30 rounded half away from zero; c is Q1.30 within plus or minus one.
  function automatic logic signed [36:0] mul_q30(input logic signed [36:0] d,
                                                 input logic signed [31:0] c);
    logic [36:0] ud;
    logic [31:0] uc;
    logic [68:0] p;
    logic [36:0] r;
    logic        neg;
    neg = d[36] ^ c[31];
    ud  = d[36] ? 37'(-d) : 37'(d);
    uc  = c[31] ? 32'(-c) : 32'(c);
    p   = 69'(ud) * 69'(uc);
    r   = 37'((p + (69'd1 << 29)) >> 30);
    return neg ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [34:0] sat_ecef(input logic signed [36:0] v);
    if (v > ECEF_LIMIT) begin
      return 35'(ECEF_LIMIT);
    end
    if (v < -ECEF_LIMIT) begin
      return 35'(-ECEF_LIMIT);
    end
    return 35'(v);
  endfunction

  function automatic logic signed [35:0] sat_neu(input logic signed [38:0] v);
    if (v > NEU_LIMIT) begin
      return 36'(NEU_LIMIT);
    end
    if (v < -NEU_LIMIT) begin
      return 36'(-NEU_LIMIT);
    end
    return 36'(v);
  endfunction

endpackage

// ----- hw/rtl/gtl_cordic_cell.sv -----
// One rotation step of the pipelined CORDIC sine and cosine chain.
module gtl_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic              clk,
  input  gtl_pkg::cordic_t  din,
  output gtl_pkg::cordic_t  dout
);

  localparam logic signed [63:0] ANGLE = gtl_pkg::atan_q61(STEP);

  logic signed [63:0] xs;
  logic signed [63:0] ys;

  assign xs = $signed(din.x) >>> STEP;
  assign ys = $signed(din.y) >>> STEP;

  always_ff @(posedge clk) begin
    if (!din.z[63]) begin
      dout.x <= din.x - ys;
      dout.y <= din.y + xs;
      dout.z <= din.z - ANGLE;
    end else begin
      dout.x <= din.x + ys;
      dout.y <= din.y - xs;
      dout.z <= din.z + ANGLE;
    end
    dout.flip <= din.flip;
  end

endmodule

// ----- hw/rtl/gtl_sqrt_cell.sv -----
// One digit step of the pipelined integer square root.
module gtl_sqrt_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic            clk,
  input  gtl_pkg::sqrt_t  din,
  output gtl_pkg::sqrt_t  dout
);

  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

  logic [63:0] trial;

  assign trial = din.res + BIT;

  always_ff @(posedge clk) begin
    if (din.rem >= trial) begin
      dout.rem <= din.rem - trial;
      dout.res <= (din.res >> 1) + BIT;
    end else begin
      dout.rem <= din.rem;
      dout.res <= din.res >> 1;
    end
  end

endmodule

// ----- hw/rtl/gtl_div_cell.sv -----
// One quotient bit of the pipelined restoring divider.
module gtl_div_cell (
  input  logic           clk,
  input  gtl_pkg::div_t  din,
  output gtl_pkg::div_t  dout
);

  logic [32:0] t;

  assign t = {din.rem, din.num[32]};

  always_ff @(posedge clk) begin
    if (t >= {1'b0, din.divisor}) begin
      dout.rem <= 32'(t - {1'b0, din.divisor});
      dout.num <= {din.num[31:0], 1'b1};
    end else begin
      dout.rem <= t[31:0];
      dout.num <= {din.num[31:0], 1'b0};
    end
    dout.divisor <= din.divisor;
  end

endmodule

// ----- hw/rtl/geodetic_to_local_neu.sv -----
// Top level: WGS84 geodetic point to ECEF and local north, east, up.
//
// The block takes one point in every clock cycle and never asserts busy. Each point
// gives one result, shown on the result ports for a single cycle with done high;
// results leave in the order the points came. The pipeline holds the CORDIC rotation
// chain (one cell per step, four angles side by side), 32 square root cells, 33 divider
// cells for the prime vertical radius, and eleven stages of multiplies and sums.
// The receiver cannot hold results off, so it must take one result in every cycle.
// Origin registers must be written only while no point is in flight; the block itself
// does not enforce this.
module geodetic_to_local_neu #(
  parameter int unsigned CORDIC_STEPS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [30:0]                 latitude,
  input  logic signed [31:0]                 longitude,
  input  logic signed [31:0]                 altitude,
  output logic                               done,
  output logic signed [34:0]                 ecef_x,
  output logic signed [34:0]                 ecef_y,
  output logic signed [34:0]                 ecef_z,
  output logic signed [35:0]                 north,
  output logic signed [35:0]                 east,
  output logic signed [35:0]                 up,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gtl_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [gtl_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int unsigned N        = CORDIC_STEPS;
  localparam int unsigned LAT      = N + 76;
  localparam int unsigned SIDE_LEN = 2 + gtl_pkg::SQ_STEPS + 1 + gtl_pkg::DV_STEPS + 3;
  localparam int unsigned V_SQ     = N + 36;
  localparam int unsigned V_DV     = N + 37;

  typedef struct packed {
    logic signed [31:0] alt;
    logic signed [31:0] sl;
    logic signed [31:0] mcc;
    logic signed [31:0] mcs;
    logic signed [31:0] osc;
    logic signed [31:0] oss;
    logic signed [31:0] ocl;
    logic signed [31:0] osl;
    logic signed [31:0] oso;
    logic signed [31:0] oco;
    logic signed [31:0] occ;
    logic signed [31:0] ocs;
  } side_t;

  // Origin registers.
  logic signed [30:0] origin_lat;
  logic signed [31:0] origin_lon;
  logic signed [34:0] origin_ecef_x;
  logic signed [34:0] origin_ecef_y;
  logic signed [34:0] origin_ecef_z;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_lat    <= '0;
      origin_lon    <= '0;
      origin_ecef_x <= gtl_pkg::ORIGIN_X_RESET;
      origin_ecef_y <= '0;
      origin_ecef_z <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gtl_pkg::CFG_ORIGIN_LAT:    origin_lat    <= cfg_data[30:0];
        gtl_pkg::CFG_ORIGIN_LON:    origin_lon    <= cfg_data[31:0];
        gtl_pkg::CFG_ORIGIN_ECEF_X: origin_ecef_x <= cfg_data;
        gtl_pkg::CFG_ORIGIN_ECEF_Y: origin_ecef_y <= cfg_data;
        gtl_pkg::CFG_ORIGIN_ECEF_Z: origin_ecef_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid bits travel with the data; nothing can stall.
  logic [LAT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start};
    end
  end

  assign done = vld[LAT-1];

  // Angle scaling to Q61 for the point and origin angles.
  logic signed [32:0] units [gtl_pkg::LANES];
  logic signed [65:0] zp    [gtl_pkg::LANES];
  logic signed [63:0] zr    [gtl_pkg::LANES];
  logic signed [31:0] alt_p [N+3];

  assign units[gtl_pkg::LANE_LAT]  = 33'(latitude);
  assign units[gtl_pkg::LANE_LON]  = 33'(longitude);
  assign units[gtl_pkg::LANE_OLAT] = 33'(origin_lat);
  assign units[gtl_pkg::LANE_OLON] = 33'(origin_lon);

  always_comb begin
    for (int l = 0; l < gtl_pkg::LANES; l++) begin
      zp[l] = 66'(units[l]) * 66'(gtl_pkg::ANG_TO_Q61);
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < gtl_pkg::LANES; l++) begin
      zr[l] <= zp[l][63:0];
    end
    alt_p[0] <= altitude;
    for (int k = 1; k < N + 3; k++) begin
      alt_p[k] <= alt_p[k-1];
    end
  end

  // Fold into the half turn around zero, then the rotation chains.
  gtl_pkg::cordic_t cv [gtl_pkg::LANES][N+1];

  for (genvar l = 0; l < gtl_pkg::LANES; l++) begin : g_lane
    always_ff @(posedge clk) begin
      cv[l][0].x <= gtl_pkg::INV_GAIN_Q61;
      cv[l][0].y <= '0;
      if (zr[l] > gtl_pkg::HALF_PI_Q61) begin
        cv[l][0].z    <= zr[l] - gtl_pkg::PI_Q61;
        cv[l][0].flip <= 1'b1;
      end else if (zr[l] < -gtl_pkg::HALF_PI_Q61) begin
        cv[l][0].z    <= zr[l] + gtl_pkg::PI_Q61;
        cv[l][0].flip <= 1'b1;
      end else begin
        cv[l][0].z    <= zr[l];
        cv[l][0].flip <= 1'b0;
      end
    end

    for (genvar j = 0; j < N; j++) begin : g_step
      gtl_cordic_cell #(.STEP(j)) u_cell (
        .clk  (clk),
        .din  (cv[l][j]),
        .dout (cv[l][j+1])
      );
    end
  end

  // Sines and cosines in Q1.30.
  logic signed [31:0] sn [gtl_pkg::LANES];
  logic signed [31:0] cs [gtl_pkg::LANES];

  always_ff @(posedge clk) begin
    for (int l = 0; l < gtl_pkg::LANES; l++) begin
      if (cv[l][N].flip) begin
        sn[l] <= -gtl_pkg::to_q30(cv[l][N].y);
        cs[l] <= -gtl_pkg::to_q30(cv[l][N].x);
      end else begin
        sn[l] <= gtl_pkg::to_q30(cv[l][N].y);
        cs[l] <= gtl_pkg::to_q30(cv[l][N].x);
      end
    end
  end

  // Rotation coefficients and sin^2 of the latitude.
  side_t       sd [SIDE_LEN];
  logic [32:0] s2;
  logic [63:0] sl_sq;

  assign sl_sq = 64'(64'(sn[gtl_pkg::LANE_LAT]) * 64'(sn[gtl_pkg::LANE_LAT]));

  always_ff @(posedge clk) begin
    s2        <= 33'(sl_sq >> 28);
    sd[0].alt <= alt_p[N+2];
    sd[0].sl  <= sn[gtl_pkg::LANE_LAT];
    sd[0].mcc <= 32'(gtl_pkg::mul_q30(37'(cs[gtl_pkg::LANE_LAT]), cs[gtl_pkg::LANE_LON]));
    sd[0].mcs <= 32'(gtl_pkg::mul_q30(37'(cs[gtl_pkg::LANE_LAT]), sn[gtl_pkg::LANE_LON]));
    sd[0].osc <= 32'(gtl_pkg::mul_q30(37'(sn[gtl_pkg::LANE_OLAT]), cs[gtl_pkg::LANE_OLON]));
    sd[0].oss <= 32'(gtl_pkg::mul_q30(37'(sn[gtl_pkg::LANE_OLAT]), sn[gtl_pkg::LANE_OLON]));
    sd[0].occ <= 32'(gtl_pkg::mul_q30(37'(cs[gtl_pkg::LANE_OLAT]), cs[gtl_pkg::LANE_OLON]));
    sd[0].ocs <= 32'(gtl_pkg::mul_q30(37'(cs[gtl_pkg::LANE_OLAT]), sn[gtl_pkg::LANE_OLON]));
    sd[0].ocl <= cs[gtl_pkg::LANE_OLAT];
    sd[0].osl <= sn[gtl_pkg::LANE_OLAT];
    sd[0].oso <= sn[gtl_pkg::LANE_OLON];
    sd[0].oco <= cs[gtl_pkg::LANE_OLON];
    for (int k = 1; k < SIDE_LEN; k++) begin
      sd[k] <= sd[k-1];
    end
  end

  // 1 - e2 sin^2 in Q62, then its square root.
  gtl_pkg::sqrt_t sq [gtl_pkg::SQ_STEPS+1];
  logic [57:0]    es;

  assign es = 58'(gtl_pkg::E2_Q32) * 58'(s2);

  always_ff @(posedge clk) begin
    sq[0].rem <= (64'd1 << 62) - 64'(es >> 2);
    sq[0].res <= '0;
  end

  for (genvar j = 0; j < gtl_pkg::SQ_STEPS; j++) begin : g_sqrt
    gtl_sqrt_cell #(.STEP(j)) u_cell (
      .clk  (clk),
      .din  (sq[j]),
      .dout (sq[j+1])
    );
  end

  // N = a * 2^31 / r, rounded; the quotient is known to fit in 33 bits.
  gtl_pkg::div_t dv [gtl_pkg::DV_STEPS+1];
  logic [31:0]   r_root;
  logic [63:0]   dividend;

  assign r_root   = sq[gtl_pkg::SQ_STEPS].res[31:0];
  assign dividend = (64'(gtl_pkg::SEMI_MAJOR_MM) << 31) + 64'(r_root >> 1);

  always_ff @(posedge clk) begin
    dv[0].rem     <= {1'b0, dividend[63:33]};
    dv[0].num     <= dividend[32:0];
    dv[0].divisor <= r_root;
  end

  for (genvar j = 0; j < gtl_pkg::DV_STEPS; j++) begin : g_div
    gtl_div_cell u_cell (
      .clk  (clk),
      .din  (dv[j]),
      .dout (dv[j+1])
    );
  end

  // Radii plus altitude.
  localparam int unsigned S7 = 2 + gtl_pkg::SQ_STEPS + 1 + gtl_pkg::DV_STEPS - 1;

  logic [32:0]        n_rad;
  logic [57:0]        ne2;
  logic [32:0]        nz_rad;
  logic signed [35:0] h7;
  logic signed [35:0] hz7;

  assign n_rad  = dv[gtl_pkg::DV_STEPS].num;
  assign ne2    = 58'(n_rad) * 58'(gtl_pkg::E2_Q32);
  assign nz_rad = n_rad - 33'((ne2 + (58'd1 << 31)) >> 32);

  always_ff @(posedge clk) begin
    h7  <= $signed({3'b000, n_rad}) + 36'(sd[S7].alt);
    hz7 <= $signed({3'b000, nz_rad}) + 36'(sd[S7].alt);
  end

  // ECEF.
  logic signed [36:0] ex8, ey8, ez8;

  always_ff @(posedge clk) begin
    ex8 <= gtl_pkg::mul_q30(37'(h7), sd[S7+1].mcc);
    ey8 <= gtl_pkg::mul_q30(37'(h7), sd[S7+1].mcs);
    ez8 <= gtl_pkg::mul_q30(37'(hz7), sd[S7+1].sl);
  end

  // Offset from the origin; saturated ECEF rides along to the output.
  logic signed [36:0] dx9, dy9, dz9;
  logic signed [34:0] ex9, ey9, ez9;
  logic signed [34:0] ex10, ey10, ez10;

  always_ff @(posedge clk) begin
    dx9  <= ex8 - 37'(origin_ecef_x);
    dy9  <= ey8 - 37'(origin_ecef_y);
    dz9  <= ez8 - 37'(origin_ecef_z);
    ex9  <= gtl_pkg::sat_ecef(ex8);
    ey9  <= gtl_pkg::sat_ecef(ey8);
    ez9  <= gtl_pkg::sat_ecef(ez8);
    ex10 <= ex9;
    ey10 <= ey9;
    ez10 <= ez9;
  end

  // Rotation terms, each rounded to millimetres on its own.
  logic signed [36:0] pn_x, pn_y, pn_z, pe_x, pe_y, pu_x, pu_y, pu_z;

  always_ff @(posedge clk) begin
    pn_x <= gtl_pkg::mul_q30(dx9, sd[S7+3].osc);
    pn_y <= gtl_pkg::mul_q30(dy9, sd[S7+3].oss);
    pn_z <= gtl_pkg::mul_q30(dz9, sd[S7+3].ocl);
    pe_x <= gtl_pkg::mul_q30(dx9, sd[S7+3].oso);
    pe_y <= gtl_pkg::mul_q30(dy9, sd[S7+3].oco);
    pu_x <= gtl_pkg::mul_q30(dx9, sd[S7+3].occ);
    pu_y <= gtl_pkg::mul_q30(dy9, sd[S7+3].ocs);
    pu_z <= gtl_pkg::mul_q30(dz9, sd[S7+3].osl);
  end

  logic signed [38:0] north_sum, east_sum, up_sum;

  assign north_sum = 39'(pn_z) - 39'(pn_x) - 39'(pn_y);
  assign east_sum  = 39'(pe_y) - 39'(pe_x);
  assign up_sum    = 39'(pu_x) + 39'(pu_y) + 39'(pu_z);

  always_ff @(posedge clk) begin
    ecef_x <= ex10;
    ecef_y <= ey10;
    ecef_z <= ez10;
    north  <= gtl_pkg::sat_neu(north_sum);
    east   <= gtl_pkg::sat_neu(east_sum);
    up     <= gtl_pkg::sat_neu(up_sum);
  end

`ifndef SYNTHESIS
  a_no_done_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe straight after reset");

  a_root_nonzero: assert property (@(posedge clk) disable iff (rst)
    vld[V_SQ] |-> r_root != 32'd0)
    else $error("square root of the radius term is zero");

  a_div_start_rem: assert property (@(posedge clk) disable iff (rst)
    vld[V_DV] |-> dv[0].rem < dv[0].divisor)
    else $error("quotient would not fit in the divider");

  a_ecef_bounds: assert property (@(posedge clk) disable iff (rst)
    done |-> (37'(ecef_x) <= gtl_pkg::ECEF_LIMIT) && (37'(ecef_x) >= -gtl_pkg::ECEF_LIMIT)
          && (37'(ecef_z) <= gtl_pkg::ECEF_LIMIT) && (37'(ecef_z) >= -gtl_pkg::ECEF_LIMIT))
    else $error("ECEF result beyond its limit");

  a_neu_bounds: assert property (@(posedge clk) disable iff (rst)
    done |-> (39'(north) <= gtl_pkg::NEU_LIMIT) && (39'(north) >= -gtl_pkg::NEU_LIMIT)
          && (39'(up) <= gtl_pkg::NEU_LIMIT) && (39'(up) >= -gtl_pkg::NEU_LIMIT))
    else $error("NEU result beyond its limit");
`endif

endmodule

// ----- tb/geodetic_to_local_neu_tb.sv -----
// Self-checking testbench for the geodetic to local north/east/up converter.
module geodetic_to_local_neu_tb;

  localparam int unsigned STEPS = 32;
  localparam int unsigned LATENCY = STEPS + 76;
  localparam int unsigned N_PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 190;
  localparam longint CYCLE_LIMIT = 400000;
  localparam longint ECEF_MAX = 64'sd9000000000;
  localparam longint NEU_MAX = 64'sd18000000000;
  localparam longint ANGLE_SCALE = 64'sd4024455255;
  localparam longint PI_FIX = 64'sd7244019458116584570;
  localparam longint HALF_PI_FIX = 64'sd3622009729058292285;
  localparam longint QUARTER_PI_FIX = 64'sd1811004864529146143;
  localparam longint INV_GAIN_FIX = 64'sd1400229935014726478;
  localparam longint unsigned ECC_Q32 = 64'd28752143;
  localparam longint unsigned EQ_RADIUS_MM = 64'd6378137000;
  localparam longint ORIGIN_X_MIN = -(64'sd1 << 34);
  localparam longint ORIGIN_X_MAX = (64'sd1 << 34) - 1;

  typedef struct {
    logic signed [34:0] ex;
    logic signed [34:0] ey;
    logic signed [34:0] ez;
    logic signed [35:0] n;
    logic signed [35:0] e;
    logic signed [35:0] u;
  } position_t;

  typedef struct {
    longint lat;
    longint lon;
    longint alt;
    longint ox;
    bit     fix_up;
    longint up_val;
  } point_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [30:0] latitude = '0;
  logic signed [31:0] longitude = '0;
  logic signed [31:0] altitude = '0;
  logic done;
  logic signed [34:0] ecef_x, ecef_y, ecef_z;
  logic signed [35:0] north, east, up;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [gtl_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [gtl_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  geodetic_to_local_neu #(.CORDIC_STEPS(STEPS)) dut (.*);

  always #6 clk = ~clk;

  longint org_lat, org_lon, org_x, org_y, org_z;
  longint atan_tab[STEPS];
  position_t pending_q[$];
  int errors = 0;
  longint cycles = 0;

  function automatic longint sx(longint unsigned v, int w);
    longint unsigned m;
    m = (64'd1 << w) - 1;
    v = v & m;
    if (v[w-1]) return longint'(v | ~m);
    return longint'(v);
  endfunction

  function automatic longint atan_term(int unsigned i);
    longint sum;
    int unsigned s;
    sum = 0;
    if (i == 0) return QUARTER_PI_FIX;
    for (int unsigned k = 0; k < 64; k++) begin
      s = i * (2 * k + 1);
      if (s > 61) break;
      if (k % 2 == 1) sum -= longint'((64'd1 << (61 - s)) / (2 * k + 1));
      else sum += longint'((64'd1 << (61 - s)) / (2 * k + 1));
    end
    return sum;
  endfunction

  function automatic longint round_q30(longint v);
    longint r;
    r = (v + (64'sd1 << 30)) >>> 31;
    if (r > (64'sd1 << 30)) r = 64'sd1 << 30;
    if (r < -(64'sd1 << 30)) r = -(64'sd1 << 30);
    return r;
  endfunction

  function automatic void rotate_angle(input longint units, output longint s, output longint c);
    longint z, x, y, xs, ys;
    bit flip;
    z = units * ANGLE_SCALE;
    x = INV_GAIN_FIX;
    y = 0;
    flip = 0;
    if (z > HALF_PI_FIX) begin
      z -= PI_FIX;
      flip = 1;
    end else if (z < -HALF_PI_FIX) begin
      z += PI_FIX;
      flip = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_tab[i];
      end else begin
        x += ys; y -= xs; z += atan_tab[i];
      end
    end
    s = round_q30(y);
    c = round_q30(x);
    if (flip) begin
      s = -s;
      c = -c;
    end
  endfunction

  // Product with a Q1.30 factor, rounded half away from zero.
  function automatic longint scale_q30(longint d, longint c);
    longint unsigned ud, uc;
    logic [127:0] p;
    longint r;
    ud = d < 0 ? longint'(-d) : d;
    uc = c < 0 ? longint'(-c) : c;
    p = 128'(ud) * 128'(uc);
    r = longint'((p + (128'd1 << 29)) >> 30);
    return ((d < 0) != (c < 0)) ? -r : r;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned w);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > w) b >>= 2;
    while (b != 0) begin
      if (w >= res + b) begin
        w -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint clip(longint v, longint lim);
    return v > lim ? lim : (v < -lim ? -lim : v);
  endfunction

  function automatic position_t convert_point(longint lat, longint lon, longint alt);
    longint sl, cl, so, co, osl, ocl, oso, oco;
    longint unsigned s2, w, r, nr;
    longint rn, rnz, h, ex, ey, ez, dx, dy, dz, nn, ee, uu;
    position_t p;
    rotate_angle(lat, sl, cl);
    rotate_angle(lon, so, co);
    s2 = longint'(sl * sl) >> 28;
    w = (64'd1 << 62) - ((ECC_Q32 * s2) >> 2);
    r = int_sqrt(w);
    if (r == 0) r = 1;
    nr = ((EQ_RADIUS_MM << 31) + (r >> 1)) / r;
    rn = longint'(nr);
    rnz = rn - longint'((nr * ECC_Q32 + (64'd1 << 31)) >> 32);
    h = rn + alt;
    ex = scale_q30(h, scale_q30(cl, co));
    ey = scale_q30(h, scale_q30(cl, so));
    ez = scale_q30(rnz + alt, sl);
    rotate_angle(org_lat, osl, ocl);
    rotate_angle(org_lon, oso, oco);
    dx = ex - org_x;
    dy = ey - org_y;
    dz = ez - org_z;
    nn = -scale_q30(dx, scale_q30(osl, oco)) - scale_q30(dy, scale_q30(osl, oso))
         + scale_q30(dz, ocl);
    ee = -scale_q30(dx, oso) + scale_q30(dy, oco);
    uu = scale_q30(dx, scale_q30(ocl, oco)) + scale_q30(dy, scale_q30(ocl, oso))
         + scale_q30(dz, osl);
    p.ex = 35'(clip(ex, ECEF_MAX));
    p.ey = 35'(clip(ey, ECEF_MAX));
    p.ez = 35'(clip(ez, ECEF_MAX));
    p.n = 36'(clip(nn, NEU_MAX));
    p.e = 36'(clip(ee, NEU_MAX));
    p.u = 36'(clip(uu, NEU_MAX));
    return p;
  endfunction

  task automatic write_origin(logic [gtl_pkg::CFG_INDEX_W-1:0] idx, longint val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= gtl_pkg::CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      gtl_pkg::CFG_ORIGIN_LAT: org_lat = sx(val, 31);
      gtl_pkg::CFG_ORIGIN_LON: org_lon = sx(val, 32);
      gtl_pkg::CFG_ORIGIN_ECEF_X: org_x = sx(val, 35);
      gtl_pkg::CFG_ORIGIN_ECEF_Y: org_y = sx(val, 35);
      gtl_pkg::CFG_ORIGIN_ECEF_Z: org_z = sx(val, 35);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Drives one point from a falling edge and records its prediction on the accepting beat.
  // Start stays high after the beat, so a following point with no gap goes back to back.
  task automatic send_point(longint lat, longint lon, longint alt, int gap,
                            bit fix_up, longint up_val);
    position_t p;
    if (gap != 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    latitude <= 31'(lat);
    longitude <= 32'(lon);
    altitude <= 32'(alt);
    do @(posedge clk); while (busy);
    p = convert_point(sx(lat, 31), sx(lon, 32), sx(alt, 32));
    if (fix_up) p.u = 36'(up_val);
    pending_q = {pending_q, p};
  endtask

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    position_t p;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("geodetic_to_local_neu_tb failed");
      $finish;
    end
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        $error("result with no point outstanding");
        errors++;
      end else begin
        p = pending_q.pop_front();
        check_field("ecef_x", p.ex, ecef_x);
        check_field("ecef_y", p.ey, ecef_y);
        check_field("ecef_z", p.ez, ecef_z);
        check_field("north", p.n, north);
        check_field("east", p.e, east);
        check_field("up", p.u, up);
      end
    end
  end

  function automatic longint pick_angle(longint lim, int w);
    case ($urandom_range(5))
      0: return lim;
      1: return -lim;
      2: return sx($urandom, w);
      default: return longint'($urandom_range(32'(2 * lim))) - lim;
    endcase
  endfunction

  initial begin
    point_row_t rows[$];
    position_t o;
    longint cur_ox, lat, lon, alt, olat, olon;
    int gap_max;
    for (int i = 0; i < STEPS; i++) atan_tab[i] = atan_term(i);
    org_lat = 0;
    org_lon = 0;
    org_x = 64'sd6378137000;
    org_y = 0;
    org_z = 0;
    cur_ox = org_x;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    rows = '{
      '{0, 0, 0, 64'sd6378137000, 0, 0},
      '{900000000, 0, 0, 64'sd6378137000, 0, 0},
      '{-900000000, 0, 0, 64'sd6378137000, 0, 0},
      '{0, 1800000000, 0, 64'sd6378137000, 0, 0},
      '{0, -1800000000, 0, 64'sd6378137000, 0, 0},
      '{0, 900000000, 0, 64'sd6378137000, 0, 0},
      '{0, -900000000, 0, 64'sd6378137000, 0, 0},
      '{450000000, 450000000, 100000, 64'sd6378137000, 0, 0},
      '{-450000000, -1350000000, -10000000, 64'sd6378137000, 0, 0},
      '{300000000, 1200000000, 2000000000, 64'sd6378137000, 0, 0},
      '{-(64'sd1 << 30), -(64'sd1 << 31), -(64'sd1 << 31), 64'sd6378137000, 0, 0},
      '{(64'sd1 << 30) - 1, (64'sd1 << 31) - 1, (64'sd1 << 31) - 1, 64'sd6378137000, 0, 0},
      '{900000001, 1800000001, 0, 64'sd6378137000, 0, 0},
      '{-900000001, -1800000001, 0, 64'sd6378137000, 0, 0},
      '{1, 1, 1, 64'sd6378137000, 0, 0},
      '{-1, -1, -1, 64'sd6378137000, 0, 0},
      // A far negative or positive origin pushes the up offset past its limit.
      '{0, 0, 0, ORIGIN_X_MIN, 1, NEU_MAX},
      '{0, 0, 2000000000, ORIGIN_X_MIN, 1, NEU_MAX},
      '{0, 1800000000, 0, ORIGIN_X_MAX, 1, -NEU_MAX},
      '{0, -1800000000, 2000000000, ORIGIN_X_MAX, 1, -NEU_MAX}
    };
    foreach (rows[i]) begin
      if (rows[i].ox != cur_ox) begin
        drain();
        write_origin(gtl_pkg::CFG_ORIGIN_ECEF_X, rows[i].ox);
        cur_ox = rows[i].ox;
      end
      send_point(rows[i].lat, rows[i].lon, rows[i].alt, i % 3, rows[i].fix_up, rows[i].up_val);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      olat = (ph == 0) ? 900000000 : (ph == 1) ? -900000000 : pick_angle(900000000, 31);
      olon = (ph == 0) ? 1800000000 : (ph == 1) ? -1800000000 : pick_angle(1800000000, 32);
      write_origin(gtl_pkg::CFG_ORIGIN_LAT, olat);
      write_origin(gtl_pkg::CFG_ORIGIN_LON, olon);
      if (ph == 2) begin
        write_origin(gtl_pkg::CFG_ORIGIN_ECEF_X, ORIGIN_X_MAX);
        write_origin(gtl_pkg::CFG_ORIGIN_ECEF_Y, ORIGIN_X_MIN);
        write_origin(gtl_pkg::CFG_ORIGIN_ECEF_Z, ORIGIN_X_MAX);
      end else if (ph == 3) begin
        write_origin(gtl_pkg::CFG_ORIGIN_ECEF_X, {$urandom, $urandom});
        write_origin(gtl_pkg::CFG_ORIGIN_ECEF_Y, {$urandom, $urandom});
        write_origin(gtl_pkg::CFG_ORIGIN_ECEF_Z, {$urandom, $urandom});
      end else begin
        // Origin derived from its own latitude and longitude, up to 5 km above the surface.
        o = convert_point(org_lat, org_lon, $urandom_range(5000000));
        write_origin(gtl_pkg::CFG_ORIGIN_ECEF_X, o.ex);
        write_origin(gtl_pkg::CFG_ORIGIN_ECEF_Y, o.ey);
        write_origin(gtl_pkg::CFG_ORIGIN_ECEF_Z, o.ez);
      end
      // Writes to indexes past the register list must leave the origin alone.
      write_origin(3'(gtl_pkg::CFG_ORIGIN_ECEF_Z + 3'd1 + 3'($urandom_range(2))),
                   {$urandom, $urandom});
      gap_max = (ph % 3 == 0) ? 0 : 8;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        case ($urandom_range(7))
          0: begin
            lat = sx($urandom, 31);
            lon = sx($urandom, 32);
            alt = sx($urandom, 32);
          end
          1, 2: begin
            lat = org_lat + longint'($urandom_range(2000000)) - 1000000;
            lon = org_lon + longint'($urandom_range(2000000)) - 1000000;
            alt = longint'($urandom_range(200000)) - 10000;
          end
          default: begin
            lat = pick_angle(900000000, 31);
            lon = pick_angle(1800000000, 32);
            alt = longint'($urandom_range(2010000000)) - 10000000;
          end
        endcase
        send_point(lat, lon, alt, $urandom_range(gap_max), 0, 0);
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0) begin
      $display("geodetic_to_local_neu_tb passed");
    end else begin
      $display("geodetic_to_local_neu_tb failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/gtl_pkg.sv
hw/rtl/gtl_cordic_cell.sv
hw/rtl/gtl_sqrt_cell.sv
hw/rtl/gtl_div_cell.sv
hw/rtl/geodetic_to_local_neu.sv
tb/geodetic_to_local_neu_tb.sv
